// ===== rtl/utd_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder: decoder state and code unit types, and
// the code point constants that the decoder uses. No dependencies.
`default_nettype none

package utd_pkg;

  localparam logic [15:0] REPL_CHAR     = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SURR_LOW      = 21'h00D800;
  localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] MIN_THREE     = 21'h000800;
  localparam logic [20:0] MIN_TWO       = 21'h000080;

  localparam logic [1:0]  LEN_TWO       = 2'd1;
  localparam logic [1:0]  LEN_THREE     = 2'd2;
  localparam logic [1:0]  LEN_FOUR      = 2'd3;

  typedef struct packed {
    logic [20:0] acc;
    logic [1:0]  pending;
    logic [1:0]  seqlen;
  } dec_state_t;

  typedef struct packed {
    logic [15:0] code;
    logic        repl;
    logic        last;
  } code_unit_t;

endpackage

`default_nettype wire

// ===== rtl/utd_decode.sv =====
// Combinational step of the UTF-8 decoder: current state and one byte in,
// next state and up to two UTF-16 code units out. Depends on utd_pkg.
`default_nettype none

module utd_decode
  import utd_pkg::*;
(
  input  dec_state_t  st_cur,
  input  logic [7:0]  in_byte,
  input  logic        eoi,
  output dec_state_t  st_nxt,
  output code_unit_t  unit0,
  output code_unit_t  unit1,
  output logic [1:0]  unit_cnt
);

  logic        is_cont;
  logic [20:0] acc_shift;
  logic [1:0]  pend_dec;
  logic [20:0] min_w;
  logic        bad_cp;
  logic [19:0] supp_off;
  code_unit_t  units [2];
  logic [1:0]  n;
  logic        lead_go;
  dec_state_t  st;

  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign acc_shift = {st_cur.acc[14:0], in_byte[5:0]};
  assign pend_dec  = st_cur.pending - 2'd1;

  always_comb begin
    case (st_cur.seqlen)
      LEN_TWO:   min_w = MIN_TWO;
      LEN_THREE: min_w = MIN_THREE;
      default:   min_w = SUPP_BASE;
    endcase
  end

  assign bad_cp   = (acc_shift < min_w) ||
                    ((acc_shift >= SURR_LOW) && (acc_shift <= SURR_HIGH)) ||
                    (acc_shift > CP_MAX);
  assign supp_off = 20'(acc_shift - SUPP_BASE);

  always_comb begin
    st       = st_cur;
    n        = 2'd0;
    units[0] = '0;
    units[1] = '0;
    lead_go  = 1'b0;

    if (st_cur.pending != 2'd0) begin
      if (is_cont) begin
        st.acc     = acc_shift;
        st.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          st = '0;
          if (bad_cp) begin
            units[0] = '{code: REPL_CHAR, repl: 1'b1, last: 1'b0};
            n        = 2'd1;
          end else if (acc_shift >= SUPP_BASE) begin
            units[0] = '{code: HI_SURR_BASE | {6'd0, supp_off[19:10]}, repl: 1'b0,
                         last: 1'b0};
            units[1] = '{code: LO_SURR_BASE | {6'd0, supp_off[9:0]}, repl: 1'b0,
                         last: 1'b0};
            n        = 2'd2;
          end else begin
            units[0] = '{code: acc_shift[15:0], repl: 1'b0, last: 1'b0};
            n        = 2'd1;
          end
        end
      end else begin
        st       = '0;
        units[0] = '{code: REPL_CHAR, repl: 1'b1, last: 1'b0};
        n        = 2'd1;
        lead_go  = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end

    if (lead_go) begin
      if (in_byte[7] == 1'b0) begin
        units[n[0]] = '{code: {8'd0, in_byte}, repl: 1'b0, last: 1'b0};
        n           = n + 2'd1;
      end else if (in_byte[7:5] == 3'b110) begin
        st = '{acc: {16'd0, in_byte[4:0]}, pending: LEN_TWO, seqlen: LEN_TWO};
      end else if (in_byte[7:4] == 4'b1110) begin
        st = '{acc: {17'd0, in_byte[3:0]}, pending: LEN_THREE, seqlen: LEN_THREE};
      end else if (in_byte[7:3] == 5'b11110) begin
        st = '{acc: {18'd0, in_byte[2:0]}, pending: LEN_FOUR, seqlen: LEN_FOUR};
      end else begin
        units[n[0]] = '{code: REPL_CHAR, repl: 1'b1, last: 1'b0};
        n           = n + 2'd1;
      end
    end

    if (eoi && (st.pending != 2'd0)) begin
      st          = '0;
      units[n[0]] = '{code: REPL_CHAR, repl: 1'b1, last: 1'b0};
      n           = n + 2'd1;
    end

    if (n != 2'd0) begin
      units[n[1]].last = 1'b1;
    end
  end

  assign st_nxt   = st;
  assign unit0    = units[0];
  assign unit1    = units[1];
  assign unit_cnt = n;

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_decoder_core.sv =====
// Top level of the UTF-8 to UTF-16 stream decoder: state registers and a
// two-entry result stage around the utd_decode step. Depends on utd_pkg and utd_decode.
//
// The input channel carries one UTF-8 byte per transfer in in_tdata; in_tlast
// marks the end of the input, and a sequence still open then is flushed as
// U+FFFD. The output channel carries one UTF-16 code unit per transfer in
// out_tdata, with out_tuser set when the unit is a replacement for malformed
// input and out_tlast set on the final unit caused by an input byte.
// A byte is decoded in the cycle it is accepted and its units are offered
// on the next cycle. One byte is taken per cycle while each byte yields at
// most one unit and the receiver keeps up; a byte that yields two units (a
// surrogate pair, or a replacement followed by a new unit) holds the input
// while the second unit drains from the two-entry result stage. A byte that
// yields no unit still passes at full rate. When the receiver stalls, the
// result stage holds its units and the input is refused once a unit is
// waiting and no transfer is made.
// Reset clears the partial code point and empties the result stage.
`default_nettype none

module utf8_to_utf16_decoder_core
  import utd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] code_unit
  output logic             out_tuser,  // [0] is_replacement
  output logic             out_tlast
);

  dec_state_t st_r, st_nxt;
  code_unit_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  code_unit_t dec_u0, dec_u1;
  logic [1:0] cnt_r, cnt_nxt, dec_cnt;
  logic       in_xfer, out_xfer;

  utd_decode u_decode (
    .st_cur   (st_r),
    .in_byte  (in_tdata),
    .eoi      (in_tlast),
    .st_nxt   (st_nxt),
    .unit0    (dec_u0),
    .unit1    (dec_u1),
    .unit_cnt (dec_cnt)
  );

  assign out_tvalid = (cnt_r != 2'd0);
  assign in_tready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = slot0_r.code;
  assign out_tuser  = slot0_r.repl;
  assign out_tlast  = slot0_r.last;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (in_xfer) begin
      slot0_nxt = dec_u0;
      slot1_nxt = dec_u1;
      cnt_nxt   = dec_cnt;
    end else if (out_xfer) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_xfer) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result stage count out of range");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_tready)
    else $error("input accepted while two units wait");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (slot1_r.last && !slot0_r.last))
    else $error("last flag misplaced in unit pair");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_xfer) && (cnt_r == 2'd1)) |-> slot0_r.last)
    else $error("single unit of a byte lacks last flag");

  a_pending_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.pending != 2'd0) |-> ((st_r.seqlen != 2'd0) && (st_r.pending <= st_r.seqlen)))
    else $error("pending count exceeds sequence length");

endmodule

`default_nettype wire

// ===== tb/tb_utf8_to_utf16_decoder_core.sv =====
// Testbench for utf8_to_utf16_decoder_core: directed and random UTF-8 byte streams,
// checked unit by unit against a built-in UTF-8 to UTF-16 decoder.
// Depends on utd_pkg and the decoder core RTL.
`default_nettype none

module tb_utf8_to_utf16_decoder_core;
  import utd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int BYTE_TARGET = 1500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  logic [20:0] part_cp;
  logic [1:0]  cont_due;
  logic [1:0]  cont_total;
  code_unit_t  step_units[$];
  code_unit_t  units_due[$];
  code_unit_t  want_unit;

  int mismatches = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit idle_off = 1'b0;

  utf8_to_utf16_decoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic go_quiet();
    part_cp = '0;
    cont_due = '0;
    cont_total = '0;
  endtask

  task automatic emit(input logic [15:0] code, input logic repl);
    code_unit_t u;
    u.code = code;
    u.repl = repl;
    u.last = 1'b0;
    step_units.push_back(u);
  endtask

  task automatic start_char(input logic [7:0] b);
    if (!b[7]) begin
      emit({8'h00, b}, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      part_cp = {16'h0000, b[4:0]};
      cont_due = LEN_TWO;
      cont_total = LEN_TWO;
    end else if (b[7:4] == 4'b1110) begin
      part_cp = {17'h00000, b[3:0]};
      cont_due = LEN_THREE;
      cont_total = LEN_THREE;
    end else if (b[7:3] == 5'b11110) begin
      part_cp = {18'h00000, b[2:0]};
      cont_due = LEN_FOUR;
      cont_total = LEN_FOUR;
    end else begin
      emit(REPL_CHAR, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [20:0] off;
    step_units.delete();
    if (cont_due != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        part_cp = {part_cp[14:0], b[5:0]};
        cont_due = cont_due - 2'd1;
        if (cont_due == 2'd0) begin
          cp = part_cp;
          floor_cp = (cont_total == LEN_TWO) ? MIN_TWO :
                     (cont_total == LEN_THREE) ? MIN_THREE : SUPP_BASE;
          go_quiet();
          if (cp < floor_cp || (cp >= SURR_LOW && cp <= SURR_HIGH) || cp > CP_MAX) begin
            emit(REPL_CHAR, 1'b1);
          end else if (cp >= SUPP_BASE) begin
            off = cp - SUPP_BASE;
            emit(HI_SURR_BASE | {6'd0, off[19:10]}, 1'b0);
            emit(LO_SURR_BASE | {6'd0, off[9:0]}, 1'b0);
          end else begin
            emit(cp[15:0], 1'b0);
          end
        end
      end else begin
        go_quiet();
        emit(REPL_CHAR, 1'b1);
        start_char(b);
      end
    end else begin
      start_char(b);
    end
    if (eoi && cont_due != 2'd0) begin
      go_quiet();
      emit(REPL_CHAR, 1'b1);
    end
    if (step_units.size() > 0) step_units[step_units.size() - 1].last = 1'b1;
    foreach (step_units[i]) units_due.push_back(step_units[i]);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while (!idle_off && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, eoi);
    bytes_sent++;
  endtask

  // Encodes cp in len bytes without range checks, so overlong and out-of-range
  // forms come out as they are; only the first keep bytes are sent.
  task automatic send_seq(input logic [20:0] cp, input int len, input int keep,
                          input logic eoi);
    logic [7:0] seq_bytes[4];
    case (len)
      1: begin
        seq_bytes[0] = cp[7:0];
      end
      2: begin
        seq_bytes[0] = {3'b110, cp[10:6]};
        seq_bytes[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq_bytes[0] = {4'b1110, cp[15:12]};
        seq_bytes[1] = {2'b10, cp[11:6]};
        seq_bytes[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq_bytes[0] = {5'b11110, cp[20:18]};
        seq_bytes[1] = {2'b10, cp[17:12]};
        seq_bytes[2] = {2'b10, cp[11:6]};
        seq_bytes[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(seq_bytes[i], eoi && (i == keep - 1));
  endtask

  task automatic send_random_char();
    int pick;
    int len;
    logic eoi;
    logic [20:0] cp;
    pick = int'($urandom_range(99));
    eoi = ($urandom_range(19) == 0);
    if (pick < 10) begin
      send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
    end else if (pick < 20) begin
      len = int'($urandom_range(2, 4));
      cp = 21'($urandom_range(21'h1FFFFF));
      send_seq(cp, len, int'($urandom_range(1, len - 1)), eoi);
    end else if (pick < 25) begin
      len = int'($urandom_range(2, 4));
      cp = (len == 2) ? 21'($urandom_range(21'h7F)) :
           (len == 3) ? 21'($urandom_range(21'h7FF)) : 21'($urandom_range(21'hFFFF));
      send_seq(cp, len, len, eoi);
    end else if (pick < 30) begin
      send_seq(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4, eoi);
    end else if (pick < 34) begin
      send_seq(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3, eoi);
    end else begin
      case ($urandom_range(3))
        0: send_seq(21'($urandom_range(21'h7F)), 1, 1, eoi);
        1: send_seq(21'($urandom_range(21'h80, 21'h7FF)), 2, 2, eoi);
        2: send_seq(21'($urandom_range(21'h800, 21'hFFFF)), 3, 3, eoi);
        default: send_seq(21'($urandom_range(21'h10000, 21'h10FFFF)), 4, 4, eoi);
      endcase
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (units_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_valid_forms();
    send_seq(21'h000000, 1, 1, 1'b0);
    send_seq(21'h00007F, 1, 1, 1'b0);
    send_seq(21'h000080, 2, 2, 1'b0);
    send_seq(21'h0007FF, 2, 2, 1'b0);
    send_seq(21'h000800, 3, 3, 1'b0);
    send_seq(21'h00FFFD, 3, 3, 1'b0);
    send_seq(21'h010000, 4, 4, 1'b0);
    send_seq(21'h10FFFF, 4, 4, 1'b0);
  endtask

  task automatic test_malformed();
    send_seq(21'h00D800, 3, 3, 1'b0);
    send_seq(21'h110000, 4, 4, 1'b0);
    send_seq(21'h1FFFFF, 4, 4, 1'b0);
    send_seq(21'h00007F, 2, 2, 1'b0);
    send_seq(21'h0007FF, 3, 3, 1'b0);
    send_seq(21'h00FFFF, 4, 4, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
  endtask

  task automatic test_end_of_input();
    send_seq(21'h01F600, 4, 3, 1'b1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h5A, 1'b1);
    send_seq(21'h0020AC, 3, 3, 1'b1);
  endtask

  task automatic test_backpressure();
    while (hold_left != 0) @(posedge clk);
    hold_left <= HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_seq(21'($urandom_range(21'h10000, 21'h10FFFF)), 4, 4, 1'b0);
    end
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_random_char();
    wait_drained();
    for (int i = 0; i < 20; i++) send_random_char();
  endtask

  task automatic test_full_rate();
    idle_off = 1'b1;
    for (int i = 0; i < 100; i++) send_random_char();
    idle_off = 1'b0;
  endtask

  task automatic test_random_stream();
    while (bytes_sent < BYTE_TARGET) send_random_char();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_off) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (units_due.size() == 0) begin
        $error("unexpected transfer: code_unit %h, is_replacement %b, last %b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want_unit = units_due.pop_front();
        if (out_tdata !== want_unit.code) begin
          $error("code_unit: expected %h, actual %h", want_unit.code, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want_unit.repl) begin
          $error("is_replacement: expected %b, actual %b", want_unit.repl, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want_unit.last) begin
          $error("last: expected %b, actual %b", want_unit.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    go_quiet();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_valid_forms();
    test_malformed();
    test_end_of_input();
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && units_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
